// File: rtl/huffman_tree_decoder_macros.svh
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared same-cycle-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("huffman_tree_decoder: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define HFTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("huffman_tree_decoder: next-cycle check failed");

`endif

// File: rtl/hftd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Payload types, request and state codes, and controller interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hftd_pkg;

  localparam int unsigned NODE_W   = 8;
  localparam int unsigned BRANCH_W = 9;
  localparam int unsigned ENTRY_W  = 2 * BRANCH_W;
  localparam int unsigned LEN_IN_W = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BITCNT_W = 3;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_DATA  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [NODE_W-1:0]   node_index;
    logic [BRANCH_W-1:0] branch_zero;
    logic [BRANCH_W-1:0] branch_one;
    logic [LEN_IN_W-1:0] chunk_length;
    logic [BYTE_W-1:0]   compressed_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              chunk_done;
    logic              last_of_item;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic accept;
    logic step;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic data_go;
    logic literal;
    logic done;
    logic last_bit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Walks a loaded 255-node code tree LSB first, one bit per cycle unless stalled.
// ----------------------------------------------------------------------------
//   Channel  Signals                      Beat contents
//   in       in_valid_i / in_stall_o      load node, start chunk or data byte
//   out      out_valid_o / out_stall_i    decoded byte, chunk done, last flag
//
// Load and start beats, and data beats with no active chunk, end at the accept.
// A data beat goes through the accept, a walk step per coded bit, each fed by
// the dependent node-table read, and a flush of the last result.
// A chunk that ends inside a byte stops the walk at that bit.
// A stalled output holds the walk when a new literal needs the output register.
// Reset is asynchronous and active low; the node table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder #(
  parameter int unsigned NODE_COUNT  = 255,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hftd_pkg::in_item_t in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hftd_pkg::out_item_t     out_o
);

  hftd_pkg::ctl_cmd_t   cmd;
  hftd_pkg::dp_status_t status;

  hftd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hftd_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// File: rtl/hftd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hftd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 255
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/hftd_ctrl.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder controller
// Sequences one input beat at a time: accept, bit walk, and final flush.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_tree_decoder_macros.svh"

module hftd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hftd_pkg::dp_status_t status_i,
  output hftd_pkg::ctl_cmd_t       cmd_o
);

  hftd_pkg::state_e state_q, state_d;
  logic             step_ok;

  // A literal can only retire the previous pending result when the output
  // register is able to take it.
  assign step_ok = !(status_i.literal && status_i.pend_valid && !status_i.out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      hftd_pkg::ST_IDLE: begin
        if (status_i.data_go) begin
          state_d = hftd_pkg::ST_WALK;
        end
      end
      hftd_pkg::ST_WALK: begin
        if (step_ok && (status_i.done || status_i.last_bit)) begin
          state_d = hftd_pkg::ST_FLUSH;
        end
      end
      hftd_pkg::ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          state_d = hftd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hftd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      hftd_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.idle   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      hftd_pkg::ST_WALK: begin
        cmd_o.step = step_ok;
      end
      hftd_pkg::ST_FLUSH: begin
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hftd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HFTD_ASSERT_NXT(a_walk_ends, clk_i, rst_ni, cmd_o.step && (status_i.done || status_i.last_bit), state_q == hftd_pkg::ST_FLUSH)
  `HFTD_ASSERT_IMP(a_step_room, clk_i, rst_ni, cmd_o.step && status_i.literal && status_i.pend_valid, status_i.out_free)
  `HFTD_ASSERT_NXT(a_data_walks, clk_i, rst_ni, (state_q == hftd_pkg::ST_IDLE) && status_i.data_go, state_q == hftd_pkg::ST_WALK)

endmodule

`default_nettype wire

// File: rtl/hftd_datapath.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder datapath
// Node table, walk state, chunk counter, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_tree_decoder_macros.svh"

module hftd_datapath #(
  parameter int unsigned NODE_COUNT  = 255,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire hftd_pkg::in_item_t   in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hftd_pkg::out_item_t       out_o,
  input  wire hftd_pkg::ctl_cmd_t   cmd_i,
  output hftd_pkg::dp_status_t      status_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam logic [hftd_pkg::NODE_W-1:0] HEAD_NODE = hftd_pkg::NODE_W'(NODE_COUNT - 1);
  localparam logic [hftd_pkg::NODE_W:0]   NODE_LIMIT = (hftd_pkg::NODE_W + 1)'(NODE_COUNT);

  logic [hftd_pkg::NODE_W-1:0]   node_q, node_next;
  logic [LENGTH_BITS-1:0]        rem_q, rem_dec, len_in;
  logic                          active_q;
  logic [hftd_pkg::BYTE_W-1:0]   shift_q;
  logic [hftd_pkg::BITCNT_W-1:0] bit_cnt_q;
  logic                          pend_valid_q;
  logic [hftd_pkg::BYTE_W-1:0]   pend_byte_q;
  logic                          pend_done_q;
  logic                          out_valid_q;
  hftd_pkg::out_item_t           out_q;

  logic [hftd_pkg::ENTRY_W-1:0]  rdata;
  logic [hftd_pkg::BRANCH_W-1:0] branch;
  logic                          literal, done, last_bit, out_free, push_mid, push_last;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_raddr;

  // Bit 0 of the shift register is the next coded bit, least significant first.
  assign branch   = shift_q[0] ? rdata[hftd_pkg::ENTRY_W-1:hftd_pkg::BRANCH_W]
                               : rdata[hftd_pkg::BRANCH_W-1:0];
  assign literal  = !branch[hftd_pkg::BRANCH_W-1];
  assign rem_dec  = rem_q - LENGTH_BITS'(1);
  assign done     = literal && (rem_dec == '0);
  assign last_bit = (bit_cnt_q == '1);
  assign len_in   = LENGTH_BITS'(in_i.chunk_length);
  assign out_free = !out_valid_q || !out_stall_i;

  // A pointer to a node outside the table sends the walk back to the head.
  always_comb begin
    if (literal) begin
      node_next = HEAD_NODE;
    end else if ({1'b0, branch[hftd_pkg::NODE_W-1:0]} < NODE_LIMIT) begin
      node_next = branch[hftd_pkg::NODE_W-1:0];
    end else begin
      node_next = HEAD_NODE;
    end
  end

  assign push_mid  = cmd_i.step && literal && pend_valid_q;
  assign push_last = cmd_i.flush;

  assign ram_we    = cmd_i.accept && (in_i.req_type == hftd_pkg::REQ_LOAD)
                     && ({1'b0, in_i.node_index} < NODE_LIMIT);
  // The next bit's node is fetched as soon as this bit resolves.
  assign ram_re    = cmd_i.idle || (cmd_i.step && !done && !last_bit);
  assign ram_raddr = cmd_i.idle ? AW'(node_q) : AW'(node_next);

  hftd_ram #(
    .WIDTH (hftd_pkg::ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.node_index)),
    .wdata_i ({in_i.branch_one, in_i.branch_zero}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q       <= HEAD_NODE;
      rem_q        <= '0;
      active_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && (in_i.req_type == hftd_pkg::REQ_START) && (len_in != '0)) begin
        rem_q    <= len_in;
        node_q   <= HEAD_NODE;
        active_q <= 1'b1;
      end
      if (cmd_i.step) begin
        node_q <= node_next;
        if (literal) begin
          rem_q        <= rem_dec;
          pend_valid_q <= 1'b1;
          if (done) begin
            active_q <= 1'b0;
          end
        end
      end
      if (push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      shift_q   <= in_i.compressed_byte;
      bit_cnt_q <= '0;
    end else if (cmd_i.step) begin
      shift_q   <= shift_q >> 1;
      bit_cnt_q <= bit_cnt_q + hftd_pkg::BITCNT_W'(1);
    end
    if (cmd_i.step && literal) begin
      pend_byte_q <= branch[hftd_pkg::BYTE_W-1:0];
      pend_done_q <= done;
    end
    if (push_mid || push_last) begin
      out_q.out_byte     <= pend_byte_q;
      out_q.chunk_done   <= pend_done_q;
      out_q.last_of_item <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    status_o            = '0;
    status_o.data_go    = in_valid_i && (in_i.req_type == hftd_pkg::REQ_DATA) && active_q;
    status_o.literal    = literal;
    status_o.done       = done;
    status_o.last_bit   = last_bit;
    status_o.pend_valid = pend_valid_q;
    status_o.out_free   = out_free;
  end

  `HFTD_ASSERT_IMP(a_active_len, clk_i, rst_ni, active_q, rem_q != '0)
  `HFTD_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_mid || push_last, out_free)
  `HFTD_ASSERT_NXT(a_done_stops, clk_i, rst_ni, cmd_i.step && done, !active_q)

endmodule

`default_nettype wire

// File: tb/tb_huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder testbench
// Loads code trees node by node, starts chunks and feeds coded bytes through
// the valid/stall input channel. A behavioral decoder in the bench predicts
// every literal with its done and last flags. Each output beat is checked
// field by field against the oldest prediction. A short directed list comes
// first. Random tree, start and data sequences follow, mixed with mostly
// ignored noise, under three idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  typedef hftd_pkg::in_item_t  in_item_t;
  typedef hftd_pkg::out_item_t out_item_t;

  localparam logic [1:0] REQ_LOAD    = hftd_pkg::REQ_LOAD;
  localparam logic [1:0] REQ_START   = hftd_pkg::REQ_START;
  localparam logic [1:0] REQ_DATA    = hftd_pkg::REQ_DATA;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         NODES       = 255;
  localparam logic [7:0] HEAD_NODE   = 8'd254;
  localparam logic [7:0] NO_NODE     = 8'd255;
  localparam logic [8:0] LIT_LIMIT   = 9'd256;
  localparam logic [8:0] MISSING_PTR = 9'd511;
  localparam int         HOLD_CYCLES = 400;
  localparam int         QUIET_LIMIT = 5000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         PHASE_ITEMS = 119;

  typedef struct {
    in_item_t  item;
    int        n_typed;  // -1 means the bench decoder supplies the results
    out_item_t typed;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  // Bench copy of the decoder state.
  logic [17:0] tree_mem [NODES];
  bit          node_seen [NODES];
  logic [7:0]  loaded_nodes [$];
  logic [7:0]  walk_node = HEAD_NODE;
  logic [23:0] bytes_left = '0;
  bit          chunk_on = 1'b0;

  out_item_t decoded_q [$];
  int        sent_items = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        source_idle_pct = 0;
  int        sink_idle_pct = 0;
  bit        hold_armed = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;

  huffman_tree_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the bench decoder by one accepted input beat and returns the
  // literals it emits.
  function automatic int decode_item(input in_item_t it, output out_item_t lits [8]);
    int         n;
    logic [8:0] br;
    n = 0;
    for (int k = 0; k < 8; k++) lits[k] = '0;
    case (it.req_type)
      REQ_LOAD: begin
        if (it.node_index < NODES) begin
          tree_mem[it.node_index] = {it.branch_one, it.branch_zero};
          if (!node_seen[it.node_index]) begin
            node_seen[it.node_index] = 1'b1;
            loaded_nodes.push_back(it.node_index);
          end
        end
      end
      REQ_START: begin
        if (it.chunk_length != '0) begin
          bytes_left = it.chunk_length;
          walk_node = HEAD_NODE;
          chunk_on = 1'b1;
        end
      end
      REQ_DATA: begin
        if (chunk_on) begin
          for (int b = 0; b < 8 && chunk_on; b++) begin
            br = it.compressed_byte[b] ? tree_mem[walk_node][17:9]
                                       : tree_mem[walk_node][8:0];
            if (br < LIT_LIMIT) begin
              bytes_left = bytes_left - 24'd1;
              walk_node = HEAD_NODE;
              lits[n].out_byte = br[7:0];
              lits[n].chunk_done = (bytes_left == '0);
              if (bytes_left == '0) chunk_on = 1'b0;
              n++;
            end else if (br == MISSING_PTR) begin
              walk_node = HEAD_NODE;
            end else begin
              walk_node = br[7:0];
            end
          end
          if (n > 0) lits[n-1].last_of_item = 1'b1;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Offers one beat, holds it until accepted, then records what it should
  // produce. Returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t it, input int n_typed, input out_item_t typed);
    out_item_t lits [8];
    int        n;
    while ($urandom_range(99) < source_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_items++;
    n = decode_item(it, lits);
    if (n_typed < 0) begin
      for (int k = 0; k < n; k++) decoded_q.push_back(lits[k]);
    end else if (n_typed == 1) begin
      decoded_q.push_back(typed);
    end
    @(negedge clk_i);
  endtask

  function automatic in_item_t fill_item(input logic [1:0] rq);
    in_item_t it;
    it.req_type = rq;
    it.node_index = 8'($urandom);
    it.branch_zero = 9'($urandom);
    it.branch_one = 9'($urandom);
    it.chunk_length = 24'($urandom);
    it.compressed_byte = 8'($urandom);
    return it;
  endfunction

  // Branch words point at loaded nodes, the node itself or the missing node, so
  // the walk never reaches an unwritten entry.
  function automatic logic [8:0] pick_branch(input logic [7:0] self);
    int r;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(loaded_nodes.size());
    if (r < 45) return 9'($urandom_range(255));
    if (r < 92) return LIT_LIMIT + {1'b0, (k == loaded_nodes.size()) ? self : loaded_nodes[k]};
    return MISSING_PTR;
  endfunction

  task automatic send_load();
    in_item_t it;
    int       r;
    it = fill_item(REQ_LOAD);
    r = $urandom_range(99);
    if (r < 30) it.node_index = HEAD_NODE;
    else if (r < 33) it.node_index = NO_NODE;
    else it.node_index = 8'($urandom_range(254));
    it.branch_zero = pick_branch(it.node_index);
    it.branch_one = pick_branch(it.node_index);
    send_item(it, -1, '0);
  endtask

  // Up to four node loads, a chunk start and a run of coded bytes mixed with node loads, all random.
  task automatic send_sequence();
    in_item_t it;
    int       r;
    repeat ($urandom_range(4)) send_load();
    it = fill_item(REQ_START);
    r = $urandom_range(99);
    if (r < 70) it.chunk_length = 24'($urandom_range(12, 1));
    else if (r < 85) it.chunk_length = 24'($urandom_range(300, 13));
    else if (r < 95) it.chunk_length = 24'($urandom);
    else it.chunk_length = 24'hFF_FFFF;
    send_item(it, -1, '0);
    repeat ($urandom_range(8, 1)) begin
      if ($urandom_range(99) < 15) send_load();
      else send_item(fill_item(REQ_DATA), -1, '0);
    end
  endtask

  task automatic send_noise();
    in_item_t it;
    case ($urandom_range(3))
      0: it = fill_item(REQ_UNKNOWN);
      1: begin
        it = fill_item(REQ_LOAD);
        it.node_index = NO_NODE;
      end
      2: begin
        it = fill_item(REQ_START);
        it.chunk_length = '0;
      end
      default: it = fill_item(REQ_DATA);
    endcase
    send_item(it, -1, '0);
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct);
    int first;
    source_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    first = sent_items;
    while (sent_items - first < PHASE_ITEMS) begin
      if ($urandom_range(99) < 12) send_noise();
      else send_sequence();
    end
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] rq, input logic [7:0] idx,
      input logic [8:0] b0, input logic [8:0] b1, input logic [23:0] len,
      input logic [7:0] dat, input int n_typed, input logic [7:0] ob, input logic done);
    dir_row_t r;
    r.item = '{req_type: rq, node_index: idx, branch_zero: b0, branch_one: b1,
               chunk_length: len, compressed_byte: dat};
    r.n_typed = n_typed;
    r.typed = '{out_byte: ob, chunk_done: done, last_of_item: 1'b1};
    return r;
  endfunction

  // Receiver side: random stall, plus one long hold-off while the source
  // keeps pushing so the decoder backs up into its input.
  always @(negedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: byte %02h done %0b last %0b",
                                  out_o.out_byte, out_o.chunk_done, out_o.last_of_item));
      end else begin
        want = decoded_q.pop_front();
        if (out_o.out_byte !== want.out_byte || out_o.chunk_done !== want.chunk_done ||
            out_o.last_of_item !== want.last_of_item) begin
          report_mismatch($sformatf(
            "mismatch: expected byte %02h done %0b last %0b, got byte %02h done %0b last %0b",
            want.out_byte, want.chunk_done, want.last_of_item,
            out_o.out_byte, out_o.chunk_done, out_o.last_of_item));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'hA5, 0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_UNKNOWN, 8'hFF, 9'h1FF, 9'h1FF, 24'hFF_FFFF, 8'hFF, 0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_START,   8'd0,   9'd0,   9'd0,   24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_LOAD,    NO_NODE, 9'd5,  9'd6,   24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_LOAD,    HEAD_NODE, 9'h000, 9'h0FF, 24'd0,   8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_START,   8'd0,   9'd0,   9'd0,   24'd1,      8'd0,  0, 8'd0, 1'b0));
    // Length one: the first set bit gives 0xFF and ends the chunk; the rest
    // of the byte and the next byte are dropped.
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h01, 1, 8'hFF, 1'b1));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h00, 0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_START,   8'd0,   9'd0,   9'd0,   24'hFF_FFFF, 8'd0, 0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'hFF, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h00, -1, 8'd0, 1'b0));
    // Tree changes while the chunk runs; the head gains a pointer to node 0
    // and a pointer to the missing node.
    rows.push_back(mk_row(REQ_LOAD,    8'd0,   9'h080, 9'h07F, 24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_LOAD,    HEAD_NODE, 9'd256, MISSING_PTR, 24'd0, 8'd0, 0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'hAA, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h55, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'hFF, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_LOAD,    8'd1,   9'd0,   9'd510, 24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_LOAD,    8'd0,   9'd257, 9'h080, 24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h3C, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_START,   8'd0,   9'd0,   9'd0,   24'd3,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_START,   8'd0,   9'd0,   9'd0,   24'd0,      8'd0,  0, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h96, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'hE1, -1, 8'd0, 1'b0));
    rows.push_back(mk_row(REQ_DATA,    8'd0,   9'd0,   9'd0,   24'd0,      8'h0F, -1, 8'd0, 1'b0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    source_idle_pct = 17;
    sink_idle_pct = 81;
    foreach (rows[i]) send_item(rows[i].item, rows[i].n_typed, rows[i].typed);

    run_phase(17, 81);
    run_phase(81, 17);
    hold_armed = 1'b1;
    run_phase(0, 0);
    in_valid_i <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && decoded_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hftd_pkg.sv
rtl/hftd_ram.sv
rtl/hftd_ctrl.sv
rtl/hftd_datapath.sv
rtl/huffman_tree_decoder.sv
tb/tb_huffman_tree_decoder.sv
